[design/assert_macros.svh]
// Assertion helper macros for the Elman cell blocks.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked while out of reset
`define ERCF_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("assertion failed");

// Checked on every edge, reset included
`define ERCF_ASSERT_NR(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) else $error("assertion failed");

`endif

[design/ercf_pkg.sv]
// Shared types, sizes, codes and the tanh table of the Elman cell.
// No dependencies.
`default_nettype none

package ercf_pkg;

    localparam int DIM     = 64;
    localparam int LANES   = 4;
    localparam int ROW_W   = $clog2(DIM);
    localparam int LANE_W  = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int CNT_W   = $clog2(DIM + 1);
    localparam int WADDR_W = 2 * ROW_W;
    localparam int XADDR_W = LANE_W + ROW_W;
    localparam int HADDR_W = 1 + LANE_W + ROW_W;

    // request commands
    localparam logic [2:0] CMD_WX     = 3'd0;
    localparam logic [2:0] CMD_WH     = 3'd1;
    localparam logic [2:0] CMD_BIAS   = 3'd2;
    localparam logic [2:0] CMD_HIDDEN = 3'd3;
    localparam logic [2:0] CMD_X      = 3'd4;

    // configuration register indexes
    localparam logic [1:0] REG_ACTIVE_DIM = 2'd0;
    localparam logic [1:0] REG_CACHE      = 2'd1;

    // controller to datapath
    typedef struct packed {
        logic               clr_we;
        logic               acc_init;
        logic               rd_en;
        logic               round_en;
        logic               tanh_en;
        logic               emit;
        logic               last;
        logic               copy_rd;
        logic               copy_wr;
        logic               flip;
        logic               cache;
        logic [ROW_W-1:0]   row;
        logic [ROW_W-1:0]   col;
        logic [HADDR_W-1:0] clr_addr;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic fire;
    } t_dp_stat;

    // round(4096*tanh(k/4)), k = 0..32; beyond saturates
    function automatic logic [12:0] tanh_tab(input logic [5:0] k);
        logic [12:0] t;
        case (k)
            6'd0:  t = 13'd0;
            6'd1:  t = 13'd1003;
            6'd2:  t = 13'd1893;
            6'd3:  t = 13'd2602;
            6'd4:  t = 13'd3119;
            6'd5:  t = 13'd3475;
            6'd6:  t = 13'd3707;
            6'd7:  t = 13'd3856;
            6'd8:  t = 13'd3949;
            6'd9:  t = 13'd4006;
            6'd10: t = 13'd4041;
            6'd11: t = 13'd4063;
            6'd12: t = 13'd4076;
            6'd13: t = 13'd4084;
            6'd14: t = 13'd4089;
            6'd15: t = 13'd4091;
            6'd16: t = 13'd4093;
            6'd17: t = 13'd4094;
            6'd18: t = 13'd4095;
            6'd19: t = 13'd4095;
            default: t = 13'd4096;
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

[design/ercf_ctrl.sv]
// Controller of the Elman cell: configuration registers and step sequencer.
// Depends on ercf_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module ercf_ctrl import ercf_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_valid,
    input  wire logic [1:0] i_cfg_index,
    input  wire logic [6:0] i_cfg_data,
    input  wire t_dp_stat   i_stat,
    output t_dp_cmd         o_cmd,
    output logic            o_busy
);

    typedef enum logic [9:0] {
        ST_IDLE    = 10'b0000000001,
        ST_CLEAR   = 10'b0000000010,
        ST_ROWINIT = 10'b0000000100,
        ST_MAC     = 10'b0000001000,
        ST_DRAIN   = 10'b0000010000,
        ST_ROUND   = 10'b0000100000,
        ST_TANH    = 10'b0001000000,
        ST_EMIT    = 10'b0010000000,
        ST_COPYRD  = 10'b0100000000,
        ST_COPYWR  = 10'b1000000000
    } t_state;

    t_state             r_state, n_state;
    logic [6:0]         r_active_dim;
    logic               r_cache;
    logic [CNT_W-1:0]   r_n, n_n;
    logic [CNT_W-1:0]   r_row, n_row;
    logic [CNT_W-1:0]   r_col, n_col;
    logic               r_drain, n_drain;
    logic [HADDR_W-1:0] r_clr, n_clr;
    logic [CNT_W-1:0]   w_n_eff;
    logic               w_row_last;

    // configuration registers, always ready
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_dim <= 7'd64;
            r_cache      <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_ACTIVE_DIM: r_active_dim <= i_cfg_data;
                REG_CACHE:      r_cache      <= i_cfg_data[0];
                default:        ;
            endcase
        end
    end

    // clamp active length to [1, DIM]
    always_comb begin
        if (r_active_dim == 7'd0)
            w_n_eff = CNT_W'(1);
        else if (int'(r_active_dim) > DIM)
            w_n_eff = CNT_W'(DIM);
        else
            w_n_eff = CNT_W'(r_active_dim);
    end

    assign w_row_last = (r_row == r_n - CNT_W'(1));

    // next state
    always_comb begin
        n_state = r_state;
        n_n     = r_n;
        n_row   = r_row;
        n_col   = r_col;
        n_drain = r_drain;
        n_clr   = r_clr;
        o_cmd   = '0;
        o_cmd.cache    = r_cache;
        o_cmd.row      = ROW_W'(r_row);
        o_cmd.col      = ROW_W'(r_col);
        o_cmd.clr_addr = r_clr;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_we = 1'b1;
                n_clr = r_clr + HADDR_W'(1);
                if (&r_clr) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_stat.fire) begin
                    n_n     = w_n_eff;
                    n_row   = '0;
                    n_state = ST_ROWINIT;
                end
            end
            ST_ROWINIT: begin
                o_cmd.acc_init = 1'b1;
                n_col   = '0;
                n_state = ST_MAC;
            end
            ST_MAC: begin
                o_cmd.rd_en = 1'b1;
                n_col = r_col + CNT_W'(1);
                if (r_col == r_n - CNT_W'(1)) begin
                    n_drain = 1'b0;
                    n_state = ST_DRAIN;
                end
            end
            // wait for the read and multiply stages to empty
            ST_DRAIN: begin
                n_drain = 1'b1;
                if (r_drain) n_state = ST_ROUND;
            end
            ST_ROUND: begin
                o_cmd.round_en = 1'b1;
                n_state = ST_TANH;
            end
            ST_TANH: begin
                o_cmd.tanh_en = 1'b1;
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                o_cmd.emit = 1'b1;
                o_cmd.last = w_row_last;
                n_row = r_row + CNT_W'(1);
                if (!w_row_last) begin
                    n_state = ST_ROWINIT;
                end else if (int'(r_n) == DIM) begin
                    o_cmd.flip = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_COPYRD;
                end
            end
            // carry inactive entries into the new bank
            ST_COPYRD: begin
                o_cmd.copy_rd = 1'b1;
                n_state = ST_COPYWR;
            end
            ST_COPYWR: begin
                o_cmd.copy_wr = 1'b1;
                n_row = r_row + CNT_W'(1);
                if (int'(r_row) == DIM - 1) begin
                    o_cmd.flip = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_COPYRD;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
            r_n     <= CNT_W'(1);
            r_row   <= '0;
            r_col   <= '0;
            r_drain <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_n     <= n_n;
            r_row   <= n_row;
            r_col   <= n_col;
            r_drain <= n_drain;
        end
    end

    assign o_busy = (r_state != ST_IDLE);

    `ERCF_ASSERT_NR(a_reset_clear, !i_rst_n |=> r_state == ST_CLEAR)
    `ERCF_ASSERT(a_mac_col, r_state == ST_MAC |-> r_col < r_n)
    `ERCF_ASSERT(a_emit_row, r_state == ST_EMIT |-> r_row < r_n)
    `ERCF_ASSERT(a_fire_start, (r_state == ST_IDLE && i_stat.fire) |=> r_row == '0)

endmodule

`default_nettype wire

[design/ercf_dp.sv]
// Datapath of the Elman cell: weight, bias, input and hidden memories,
// the MAC pipeline, rounding and tanh. Depends on ercf_pkg.
`default_nettype none

module ercf_dp import ercf_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_accept,
    input  wire logic [2:0]         i_cmd,
    input  wire logic [1:0]         i_lane,
    input  wire logic [5:0]         i_row,
    input  wire logic [5:0]         i_col,
    input  wire logic signed [15:0] i_value,
    input  wire logic               i_last,
    input  wire t_dp_cmd            i_dp,
    output t_dp_stat                o_stat,
    output logic                    o_valid,
    output logic [1:0]              o_out_lane,
    output logic [5:0]              o_out_index,
    output logic signed [13:0]      o_hidden_value,
    output logic signed [15:0]      o_preactivation,
    output logic                    o_out_last
);

    logic signed [15:0] wx_mem   [DIM*DIM];
    logic signed [15:0] wh_mem   [DIM*DIM];
    logic signed [15:0] bias_mem [DIM];
    logic signed [15:0] x_mem    [LANES*DIM];
    logic signed [15:0] h_mem    [2*LANES*DIM];

    logic [LANES-1:0]   r_bank;
    logic [LANE_W-1:0]  r_lane;
    logic signed [15:0] r_wx, r_wh, r_xv, r_hd, r_bias, r_v;
    logic signed [31:0] r_p1, r_p2;
    logic signed [39:0] r_acc;
    logic               r_v1, r_v2;
    logic [12:0]        r_ti;
    logic [19:0]        r_prod;
    logic               r_sat, r_neg;

    logic [ROW_W-1:0]   w_row, w_col;
    logic [LANE_W-1:0]  w_lane;
    logic               w_addr_ok, w_lane_ok;
    logic               w_cur;
    logic               h_we;
    logic [HADDR_W-1:0] h_waddr, h_raddr;
    logic signed [15:0] h_wdata;
    logic signed [39:0] w_sum;
    logic signed [27:0] w_q;
    logic signed [15:0] w_v;
    logic [15:0]        w_abs;
    logic [5:0]         w_i;
    logic [9:0]         w_f;
    logic [12:0]        w_t0, w_t1, w_t;
    logic [9:0]         w_d;
    logic signed [13:0] w_h;

    assign w_row     = ROW_W'(i_row);
    assign w_col     = ROW_W'(i_col);
    assign w_lane    = LANE_W'(i_lane);
    assign w_addr_ok = (int'(i_row) < DIM);
    assign w_lane_ok = (int'(i_lane) < LANES);
    assign w_cur     = r_bank[r_lane];

    assign o_stat.fire = i_accept && (i_cmd == CMD_X) && w_addr_ok && w_lane_ok && i_last;

    // weight, bias and input loads
    always_ff @(posedge i_clk) begin
        if (i_accept && w_addr_ok && (int'(i_col) < DIM)) begin
            if (i_cmd == CMD_WX) wx_mem[{w_row, w_col}] <= i_value;
            if (i_cmd == CMD_WH) wh_mem[{w_row, w_col}] <= i_value;
        end
        if (i_accept && w_addr_ok && (i_cmd == CMD_BIAS))
            bias_mem[w_row] <= i_value;
        if (i_accept && w_addr_ok && w_lane_ok && (i_cmd == CMD_X))
            x_mem[{w_lane, w_row}] <= i_value;
    end

    // hidden store write port
    always_comb begin
        h_we    = 1'b0;
        h_waddr = {r_bank[w_lane], w_lane, w_row};
        h_wdata = i_value;
        if (i_dp.clr_we) begin
            h_we    = 1'b1;
            h_waddr = i_dp.clr_addr;
            h_wdata = '0;
        end else if (i_dp.emit) begin
            h_we    = 1'b1;
            h_waddr = {~w_cur, r_lane, i_dp.row};
            h_wdata = 16'(w_h);
        end else if (i_dp.copy_wr) begin
            h_we    = 1'b1;
            h_waddr = {~w_cur, r_lane, i_dp.row};
            h_wdata = r_hd;
        end else if (i_accept && w_addr_ok && w_lane_ok && (i_cmd == CMD_HIDDEN)) begin
            h_we    = 1'b1;
        end
    end

    assign h_raddr = i_dp.copy_rd ? {w_cur, r_lane, i_dp.row} : {w_cur, r_lane, i_dp.col};

    // memory reads, registered
    always_ff @(posedge i_clk) begin
        if (h_we) h_mem[h_waddr] <= h_wdata;
        if (i_dp.rd_en || i_dp.copy_rd) r_hd <= h_mem[h_raddr];
        if (i_dp.rd_en) begin
            r_wx <= wx_mem[{i_dp.row, i_dp.col}];
            r_wh <= wh_mem[{i_dp.row, i_dp.col}];
            r_xv <= x_mem[{r_lane, i_dp.col}];
        end
        if (i_dp.acc_init) r_bias <= bias_mem[i_dp.row];
    end

    // step lane and bank select per lane
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank <= '0;
            r_lane <= '0;
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
        end else begin
            if (o_stat.fire) r_lane <= w_lane;
            if (i_dp.flip) r_bank[r_lane] <= ~r_bank[r_lane];
            r_v1 <= i_dp.rd_en;
            r_v2 <= r_v1;
        end
    end

    // multiply then accumulate
    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            r_p1 <= r_wx * r_xv;
            r_p2 <= r_wh * r_hd;
        end
        if (i_dp.acc_init)
            r_acc <= '0;
        else if (r_v2)
            r_acc <= r_acc + 40'(r_p1) + 40'(r_p2);
    end

    // bias, round half up, saturate to 16 bits
    always_comb begin
        w_sum = r_acc + (40'(r_bias) <<< 12) + 40'sd2048;
        w_q   = 28'(w_sum >>> 12);
        if (w_q > 28'sd32767)
            w_v = 16'sh7FFF;
        else if (w_q < -28'sd32768)
            w_v = -16'sd32768;
        else
            w_v = 16'(w_q);
    end

    // tanh table index and slope
    always_comb begin
        w_abs = r_v[15] ? 16'(-r_v) : 16'(r_v);
        w_i   = w_abs[15:10];
        w_f   = w_abs[9:0];
        w_t0  = tanh_tab(w_i);
        w_t1  = tanh_tab(w_i + 6'd1);
        w_d   = 10'(w_t1 - w_t0);
    end

    always_ff @(posedge i_clk) begin
        if (i_dp.round_en) r_v <= w_v;
        if (i_dp.tanh_en) begin
            r_ti   <= w_t0;
            r_prod <= 20'(w_d) * 20'(w_f);
            r_sat  <= (w_i >= 6'd32);
            r_neg  <= r_v[15];
        end
    end

    // interpolate and apply sign
    always_comb begin
        w_t = r_sat ? 13'd4096 : r_ti + 13'((r_prod + 20'd512) >> 10);
        w_h = r_neg ? -14'(w_t) : 14'(w_t);
    end

    // result registers, one-cycle strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_dp.emit;
        end
        if (i_dp.emit) begin
            o_out_lane      <= 2'(r_lane);
            o_out_index     <= 6'(i_dp.row);
            o_hidden_value  <= w_h;
            o_preactivation <= i_dp.cache ? r_v : 16'sd0;
            o_out_last      <= i_dp.last;
        end
    end

endmodule

`default_nettype wire

[design/elman_rnn_cell_forward_top.sv]
// Elman cell top: load/store requests are taken only while idle; a request with last
// set fires a step over the n active rows (n = active length), then copies the DIM-n
// inactive entries; the single MAC unit reads one Wx/Wh/x/h column per cycle. Results
// come one per row; the receiver cannot stall.
// After reset a clear pass zeroes the whole hidden store, busy held.
// Depends on ercf_pkg, ercf_ctrl, ercf_dp.
`default_nettype none

module elman_rnn_cell_forward_top import ercf_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [2:0]         i_cmd,
    input  wire logic [1:0]         i_lane,
    input  wire logic [5:0]         i_row,
    input  wire logic [5:0]         i_col,
    input  wire logic signed [15:0] i_value,
    input  wire logic               i_last,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [6:0]         i_cfg_data,
    output logic                    o_valid,
    output logic [1:0]              o_out_lane,
    output logic [5:0]              o_out_index,
    output logic signed [13:0]      o_hidden_value,
    output logic signed [15:0]      o_preactivation,
    output logic                    o_out_last
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;
    logic     w_accept;

    // request taken only while idle
    assign w_accept    = start && !busy;
    assign o_cfg_ready = 1'b1;

    ercf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd),
        .o_busy      (busy)
    );

    ercf_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (w_accept),
        .i_cmd           (i_cmd),
        .i_lane          (i_lane),
        .i_row           (i_row),
        .i_col           (i_col),
        .i_value         (i_value),
        .i_last          (i_last),
        .i_dp            (w_cmd),
        .o_stat          (w_stat),
        .o_valid         (o_valid),
        .o_out_lane      (o_out_lane),
        .o_out_index     (o_out_index),
        .o_hidden_value  (o_hidden_value),
        .o_preactivation (o_preactivation),
        .o_out_last      (o_out_last)
    );

endmodule

`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for elman_rnn_cell_forward_top: loads the weights and
// inputs, fires recurrent steps and checks every hidden result. Needs ercf_pkg.
module tb;
    import ercf_pkg::*;

    localparam int WDOG_LIMIT = 20000;
    // weights, bias and x are loaded up to this length; steps never go beyond it
    localparam int FILL_DIM = 6;
    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam logic [2:0] CMD_NOP_LO = 3'd5;
    localparam logic [2:0] CMD_NOP_HI = 3'd7;
    localparam int TANH_PTS [0:32] = '{
        0, 1003, 1893, 2602, 3119, 3475, 3707, 3856, 3949, 4006, 4041,
        4063, 4076, 4084, 4089, 4091, 4093, 4094, 4095, 4095, 4096, 4096,
        4096, 4096, 4096, 4096, 4096, 4096, 4096, 4096, 4096, 4096, 4096};

    typedef struct {
        logic [2:0]         cmd;
        logic [1:0]         lane;
        logic [5:0]         row;
        logic [5:0]         col;
        logic signed [15:0] value;
        logic               last;
    } t_req;

    typedef struct {
        logic [1:0]         lane;
        logic [5:0]         index;
        logic signed [13:0] hidden;
        logic signed [15:0] preact;
        logic               last;
    } t_hid_res;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [2:0] i_cmd = '0;
    logic [1:0] i_lane = '0;
    logic [5:0] i_row = '0;
    logic [5:0] i_col = '0;
    logic signed [15:0] i_value = '0;
    logic i_last = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [1:0] i_cfg_index = '0;
    logic [6:0] i_cfg_data = '0;
    logic o_valid;
    logic [1:0] o_out_lane;
    logic [5:0] o_out_index;
    logic signed [13:0] o_hidden_value;
    logic signed [15:0] o_preactivation;
    logic o_out_last;

    elman_rnn_cell_forward_top u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_cmd(i_cmd), .i_lane(i_lane), .i_row(i_row), .i_col(i_col),
        .i_value(i_value), .i_last(i_last),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_valid(o_valid), .o_out_lane(o_out_lane), .o_out_index(o_out_index),
        .o_hidden_value(o_hidden_value), .o_preactivation(o_preactivation),
        .o_out_last(o_out_last)
    );

    // predictor state
    logic signed [15:0] wx_mem [0:63][0:63];
    logic signed [15:0] wh_mem [0:63][0:63];
    logic signed [15:0] bias_mem [0:63];
    logic signed [15:0] hid_mem [0:1][0:3][0:63];
    logic signed [15:0] x_mem [0:3][0:63];
    logic [3:0] bank_sel = '0;
    logic [6:0] dim_reg = 7'd64;
    logic cache_reg = 1'b0;

    t_req req_q[$];
    t_hid_res hidden_q[$];
    t_req cur_req;
    int send_idle_pct = 13;
    int err_cnt = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int tanh_q12(input int v);
        int a;
        int i;
        int f;
        int t;
        a = (v < 0) ? -v : v;
        i = a >> 10;
        f = a & 1023;
        if (i >= 32) t = 4096;
        else t = TANH_PTS[i] + (((TANH_PTS[i+1] - TANH_PTS[i]) * f + 512) >> 10);
        return (v < 0) ? -t : t;
    endfunction

    // one recurrent step for a lane, results pushed in index order
    task automatic run_step(input logic [1:0] lane);
        int n;
        int cb;
        longint acc;
        longint q;
        int h;
        t_hid_res res;
        n = (dim_reg == 0) ? 1 : ((dim_reg > DIM) ? DIM : int'(dim_reg));
        cb = bank_sel[lane];
        for (int r = 0; r < DIM; r++) begin
            if (r >= n) begin
                hid_mem[cb^1][lane][r] = hid_mem[cb][lane][r];
                continue;
            end
            acc = longint'(bias_mem[r]) * 4096;
            for (int c = 0; c < n; c++) begin
                acc += longint'(wx_mem[r][c]) * longint'(x_mem[lane][c]);
                acc += longint'(wh_mem[r][c]) * longint'(hid_mem[cb][lane][c]);
            end
            q = (acc + 2048) >>> 12;
            if (q > 32767) q = 32767;
            if (q < -32768) q = -32768;
            h = tanh_q12(int'(q));
            hid_mem[cb^1][lane][r] = 16'(h);
            res.lane = lane;
            res.index = 6'(r);
            res.hidden = 14'(h);
            res.preact = cache_reg ? 16'(q) : 16'sd0;
            res.last = (r == n - 1);
            hidden_q.push_back(res);
        end
        bank_sel[lane] = ~bank_sel[lane];
    endtask

    task automatic apply_request(input t_req rq);
        case (rq.cmd)
            CMD_WX:     wx_mem[rq.row][rq.col] = rq.value;
            CMD_WH:     wh_mem[rq.row][rq.col] = rq.value;
            CMD_BIAS:   bias_mem[rq.row] = rq.value;
            CMD_HIDDEN: hid_mem[bank_sel[rq.lane]][rq.lane][rq.row] = rq.value;
            CMD_X: begin
                x_mem[rq.lane][rq.row] = rq.value;
                if (rq.last) run_step(rq.lane);
            end
            default: ;
        endcase
    endtask

    // request driver
    always @(posedge i_clk) begin : drv_p
        logic taken;
        taken = start && !busy;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (taken) apply_request(cur_req);
            if (!start || taken) begin
                if (req_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_req = req_q.pop_front();
                    start <= 1'b1;
                    i_cmd <= cur_req.cmd;
                    i_lane <= cur_req.lane;
                    i_row <= cur_req.row;
                    i_col <= cur_req.col;
                    i_value <= cur_req.value;
                    i_last <= cur_req.last;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin : mon_p
        t_hid_res e;
        if (i_rst_n && o_valid) begin
            if (hidden_q.size() == 0) begin
                $display("%0t: unexpected result lane %0d index %0d", $time,
                         o_out_lane, o_out_index);
                err_cnt++;
            end else begin
                e = hidden_q.pop_front();
                if (o_out_lane !== e.lane) begin
                    $display("%0t: lane exp %0d got %0d", $time, e.lane, o_out_lane);
                    err_cnt++;
                end
                if (o_out_index !== e.index) begin
                    $display("%0t: index exp %0d got %0d", $time, e.index, o_out_index);
                    err_cnt++;
                end
                if (o_hidden_value !== e.hidden) begin
                    $display("%0t: hidden exp %0d got %0d", $time, e.hidden,
                             o_hidden_value);
                    err_cnt++;
                end
                if (o_preactivation !== e.preact) begin
                    $display("%0t: preact exp %0d got %0d", $time, e.preact,
                             o_preactivation);
                    err_cnt++;
                end
                if (o_out_last !== e.last) begin
                    $display("%0t: last exp %0d got %0d", $time, e.last, o_out_last);
                    err_cnt++;
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin : wdog_p
        int quiet;
        if ((start && !busy) || o_valid || (i_cfg_valid && o_cfg_ready)) quiet = 0;
        else quiet++;
        if (quiet >= WDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic logic signed [15:0] rand_val();
        if ($urandom_range(7) == 0) return 16'($urandom);
        return 16'($urandom_range(1023)) - 16'sd512;
    endfunction

    function automatic t_req mk_req(input logic [2:0] cmd, input logic [1:0] lane,
                                    input logic [5:0] row, input logic [5:0] col,
                                    input logic signed [15:0] value, input logic last);
        t_req rq;
        rq.cmd = cmd;
        rq.lane = lane;
        rq.row = row;
        rq.col = col;
        rq.value = value;
        rq.last = last;
        return rq;
    endfunction

    // mostly loads and x vectors, with some ignored commands mixed in
    function automatic t_req rand_req();
        t_req rq;
        int kind;
        kind = $urandom_range(9);
        rq = mk_req(CMD_X, 2'($urandom), 6'($urandom), 6'($urandom), rand_val(),
                    1'b0);
        case (kind)
            0, 1: rq.cmd = CMD_WX;
            2:    rq.cmd = CMD_WH;
            3:    rq.cmd = CMD_BIAS;
            4:    rq.cmd = CMD_HIDDEN;
            9:    rq.cmd = 3'($urandom_range(CMD_NOP_LO, CMD_NOP_HI));
            default: rq.cmd = CMD_X;
        endcase
        if (rq.cmd == CMD_X) rq.last = ($urandom_range(2) == 0);
        else rq.last = 1'($urandom);
        return rq;
    endfunction

    // wait until no request or result is outstanding, then let the copy tail drain
    task automatic settle();
        do @(posedge i_clk); while (req_q.size() != 0 || start || hidden_q.size() != 0);
        repeat (2 * DIM + 16) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [6:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == REG_ACTIVE_DIM) dim_reg = data;
        else if (idx == REG_CACHE) cache_reg = data[0];
    endtask

    // stimulus and final verdict
    initial begin
        for (int b = 0; b < 2; b++)
            for (int l = 0; l < LANES; l++)
                for (int r = 0; r < DIM; r++) hid_mem[b][l][r] = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // keep steps inside the loaded region
        write_reg(REG_ACTIVE_DIM, 7'(FILL_DIM));

        // fill the weight, bias and x entries that a step of FILL_DIM reads
        for (int r = 0; r < FILL_DIM; r++) begin
            for (int c = 0; c < FILL_DIM; c++) begin
                req_q.push_back(mk_req(CMD_WX, 2'($urandom), 6'(r), 6'(c), rand_val(),
                                       1'b0));
                req_q.push_back(mk_req(CMD_WH, 2'($urandom), 6'(r), 6'(c), rand_val(),
                                       1'b0));
            end
            req_q.push_back(mk_req(CMD_BIAS, 2'($urandom), 6'(r), 6'($urandom),
                                   rand_val(), 1'b0));
            for (int l = 0; l < LANES; l++)
                req_q.push_back(mk_req(CMD_X, 2'(l), 6'(r), 6'($urandom), rand_val(),
                                       1'b0));
        end

        // directed: extremes, ignored commands, last on loads, steps at fill length
        req_q.push_back(mk_req(CMD_X, 2'd0, 6'd0, 6'd0, 16'sh7FFF, 1'b0));
        req_q.push_back(mk_req(CMD_X, 2'd0, 6'd63, 6'd63, -16'sh8000, 1'b0));
        req_q.push_back(mk_req(CMD_BIAS, 2'd3, 6'd0, 6'd63, 16'sh7FFF, 1'b1));
        req_q.push_back(mk_req(CMD_BIAS, 2'd0, 6'd63, 6'd0, -16'sh8000, 1'b0));
        req_q.push_back(mk_req(CMD_WX, 2'd3, 6'd0, 6'd63, -16'sh8000, 1'b1));
        req_q.push_back(mk_req(CMD_WH, 2'd0, 6'd63, 6'd0, 16'sh7FFF, 1'b1));
        req_q.push_back(mk_req(CMD_HIDDEN, 2'd0, 6'd5, 6'd63, -16'sh8000, 1'b1));
        req_q.push_back(mk_req(CMD_HIDDEN, 2'd3, 6'd63, 6'd0, 16'sh7FFF, 1'b0));
        req_q.push_back(mk_req(CMD_NOP_LO, 2'd3, 6'd63, 6'd63, 16'sh7FFF, 1'b1));
        req_q.push_back(mk_req(3'd6, 2'd0, 6'd0, 6'd0, 16'sd0, 1'b1));
        req_q.push_back(mk_req(CMD_NOP_HI, 2'd2, 6'd21, 6'd42, 16'sh5555, 1'b1));
        req_q.push_back(mk_req(CMD_WX, 2'd3, 6'd21, 6'd42, 16'sh2AAA, 1'b1));
        req_q.push_back(mk_req(CMD_X, 2'd0, 6'd10, 6'd0, 16'sh0100, 1'b1));
        req_q.push_back(mk_req(CMD_X, 2'd1, 6'd0, 6'd63, 16'sh0200, 1'b1));
        settle();
        write_reg(REG_CACHE, 7'h7F);
        write_reg(REG_ACTIVE_DIM, 7'd1);
        req_q.push_back(mk_req(CMD_X, 2'd2, 6'd1, 6'd0, -16'sh0100, 1'b1));
        req_q.push_back(mk_req(CMD_X, 2'd3, 6'd0, 6'd0, 16'sh7FFF, 1'b1));
        settle();
        write_reg(REG_ACTIVE_DIM, 7'd0);
        write_reg(REG_UNUSED, 7'h7F);
        req_q.push_back(mk_req(CMD_X, 2'd2, 6'd0, 6'd0, -16'sh8000, 1'b1));
        settle();

        // random segments: sender idles rarely, often, then never
        for (int s = 0; s < 6; s++) begin
            send_idle_pct = (s < 2) ? 13 : ((s < 4) ? 87 : 0);
            write_reg(REG_ACTIVE_DIM, 7'($urandom_range(1, FILL_DIM)));
            write_reg(REG_CACHE, 7'($urandom));
            for (int k = 0; k < 40; k++) req_q.push_back(rand_req());
            settle();
        end

        if (err_cnt == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
